[src/efrs_pkg.sv]
// shared types and constants for the earliest free room scheduler
`timescale 1ns / 1ps

package efrs_pkg;

  localparam int START_W = 32;
  localparam int TIME_W  = 48;
  localparam int CNT_W   = 32;
  localparam int ROOM_W  = 4;
  localparam int NUM_W   = 5;
  localparam int NEXT_W  = 9;   // holds a room count up to the largest build
  localparam logic [NUM_W-1:0] NUM_RESET = 5'd16;

  typedef struct packed {
    logic [TIME_W-1:0] free_time;
    logic [CNT_W-1:0]  use_count;
  } room_data_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_COMMIT = 7'b0001000,
    S_BEST   = 7'b0010000,
    S_DRAIN2 = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

endpackage

[src/earliest_free_room_scheduler_top.sv]
// top level of the earliest free room scheduler
`timescale 1ns / 1ps
// a request runs through S_SCAN, S_DRAIN, S_COMMIT, S_BEST, S_DRAIN2 and S_FINISH,
//   held in S_FINISH while a result stalls; the next request waits for S_IDLE after two
//   passes over the room memory at one entry per cycle (free-time scan, then count scan)
// reset: synchronous rst_n clears control, all room entries (valid bits) and sets
//   num_rooms to 16; no clearing pass, the block is ready right after reset

module earliest_free_room_scheduler_top import efrs_pkg::*; #(
  parameter int ROOMS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // start_time[31:0], end_time[63:32]
  input  logic         in_tlast,   // final_job
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // room_index[3:0], actual_start[51:4], actual_end[99:52],
  // most_used_room[103:100], most_used_count[135:104]
  output logic [135:0] out_tdata,
  output logic         out_tlast,  // is_final
  // room count register
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data    // num_rooms
);

  localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int XW = (IW > ROOM_W) ? IW : ROOM_W;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]   num_rooms_r;
  logic [IW-1:0]      addr_r, last_r, idx_r;
  logic               live_r;
  logic [START_W-1:0] start_r, dur_r;
  logic               fin_r;

  // free-time scan results
  logic               found_r;
  logic [IW-1:0]      fpick_r, earl_r;
  logic [CNT_W-1:0]   fcnt_r, ecnt_r;
  logic [TIME_W-1:0]  eft_r;

  // chosen room and its new timing
  logic [IW-1:0]      pick_r;
  logic [TIME_W-1:0]  astart_r, aend_r;

  // count scan results
  logic [IW-1:0]      best_r;
  logic [CNT_W-1:0]   bcnt_r;

  logic               out_valid_r;
  logic [135:0]       out_data_r;
  logic               out_last_r;

  // memory port
  logic               rd_en, wr_en, clear;
  room_data_t         rd_data, wr_data;

  logic               in_fire, out_load;
  logic [NEXT_W-1:0]  num_x, n_act;
  logic               scan_last;
  logic               cmp_le, cmp_lt, cmp_gt;

  // commit arithmetic
  logic [IW-1:0]      c_pick;
  logic [CNT_W-1:0]   c_cnt, c_cnt_nxt;
  logic [TIME_W-1:0]  c_start;
  logic [TIME_W:0]    c_sum;
  logic [TIME_W-1:0]  c_end;

  logic [XW-1:0]      pick_x, best_x;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // active room count, clamped to 1..ROOMS
  assign num_x = {{(NEXT_W-NUM_W){1'b0}}, num_rooms_r};
  assign n_act = (num_x == '0) ? NEXT_W'(1) :
                 (num_x > NEXT_W'(ROOMS)) ? NEXT_W'(ROOMS) : num_x;

  assign scan_last = (addr_r == last_r);
  assign rd_en     = (state_r == S_SCAN) || (state_r == S_BEST);

  // compares on the returning memory word
  assign cmp_le = rd_data.free_time <= {{(TIME_W-START_W){1'b0}}, start_r};
  assign cmp_lt = rd_data.free_time < eft_r;
  assign cmp_gt = rd_data.use_count > bcnt_r;

  // first free room wins; otherwise the earliest to free, delayed to its free time
  assign c_pick    = found_r ? fpick_r : earl_r;
  assign c_cnt     = found_r ? fcnt_r : ecnt_r;
  assign c_start   = found_r ? {{(TIME_W-START_W){1'b0}}, start_r} : eft_r;
  assign c_sum     = {1'b0, c_start} + {{(TIME_W+1-START_W){1'b0}}, dur_r};
  assign c_end     = c_sum[TIME_W] ? '1 : c_sum[TIME_W-1:0];
  assign c_cnt_nxt = (c_cnt == '1) ? c_cnt : c_cnt + CNT_W'(1);

  assign wr_en             = (state_r == S_COMMIT);
  assign wr_data.free_time = c_end;
  assign wr_data.use_count = c_cnt_nxt;

  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_tready);
  assign clear    = out_load && fin_r;

  assign pick_x = XW'(pick_r);
  assign best_x = XW'(best_r);

  efrs_room_store #(
    .ROOMS (ROOMS),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (c_pick),
    .wr_data (wr_data),
    .clear   (clear)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_BEST;
      S_BEST:   if (scan_last) state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_FINISH;
      S_FINISH: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_rooms_r <= NUM_RESET;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r  <= rd_en;
      if (cfg_valid && cfg_ready) begin
        num_rooms_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    idx_r <= addr_r;

    if (rd_en) begin
      addr_r <= scan_last ? '0 : addr_r + IW'(1);
    end

    if (in_fire) begin
      addr_r  <= '0;
      last_r  <= IW'(n_act - NEXT_W'(1));
      start_r <= in_tdata[31:0];
      dur_r   <= (in_tdata[63:32] > in_tdata[31:0]) ? in_tdata[63:32] - in_tdata[31:0] : '0;
      fin_r   <= in_tlast;
      found_r <= 1'b0;
    end

    // free-time pass
    if (live_r && ((state_r == S_SCAN) || (state_r == S_DRAIN))) begin
      if (!found_r && cmp_le) begin
        found_r <= 1'b1;
        fpick_r <= idx_r;
        fcnt_r  <= rd_data.use_count;
      end
      if ((idx_r == '0) || cmp_lt) begin
        earl_r <= idx_r;
        eft_r  <= rd_data.free_time;
        ecnt_r <= rd_data.use_count;
      end
    end

    if (state_r == S_COMMIT) begin
      pick_r   <= c_pick;
      astart_r <= c_start;
      aend_r   <= c_end;
    end

    // count pass, lowest index kept on ties
    if (live_r && ((state_r == S_BEST) || (state_r == S_DRAIN2))) begin
      if ((idx_r == '0) || cmp_gt) begin
        best_r <= idx_r;
        bcnt_r <= rd_data.use_count;
      end
    end

    if (out_load) begin
      out_data_r <= {bcnt_r, best_x[ROOM_W-1:0], aend_r, astart_r, pick_x[ROOM_W-1:0]};
      out_last_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/efrs_room_store.sv]
// room state memory: free time and use count per room, with per-room valid bits
`timescale 1ns / 1ps

module efrs_room_store import efrs_pkg::*; #(
  parameter int ROOMS = 16,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_addr,
  output room_data_t       rd_data,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  room_data_t       wr_data,
  input  logic             clear
);

  room_data_t mem_r [ROOMS];
  room_data_t rd_q_r;
  logic [ROOMS-1:0] valid_r;
  logic             rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v_r <= valid_r[rd_addr];
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

[src/efrs_checker.sv]
// port-level checks for the scheduler top level, bound to it
`timescale 1ns / 1ps

module efrs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic         out_tlast
);

  // one request in flight: ready drops right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a request");

  // a job never ends before it starts
  a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[99:52] >= out_tdata[51:4])
    else $error("actual_end below actual_start");

  // the most used count is never zero, as the room just used counts at least one
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:104] != 32'd0)
    else $error("most_used_count is zero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind earliest_free_room_scheduler_top efrs_checker u_efrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[bench/tb_top.sv]
// testbench for the earliest free room scheduler, directed and random job streams
`timescale 1ns / 1ps

module tb_top;
  import efrs_pkg::*;

  localparam int NROOMS = 16;
  localparam int RANDOM_JOBS = 1300;
  // each maximal job adds 2^32-1 to the one room's free time, so a short run
  // carries it well into the upper bits of the 48-bit time
  localparam int LONG_JOBS = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 2 * NROOMS + 8;
  localparam int MAX_PRINTED = 40;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // one predicted assignment, field for field as the result channel carries it
  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_stop;
    logic [ROOM_W-1:0] top_room;
    logic [CNT_W-1:0]  top_count;
    logic              last_flag;
  } assignment_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;    // start_time[31:0], end_time[63:32]
  logic         in_tlast = 1'b0;  // final_job
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // room_index[3:0], actual_start[51:4], actual_end[99:52],
  // most_used_room[103:100], most_used_count[135:104]
  logic [135:0] out_tdata;
  logic         out_tlast;        // is_final
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;    // num_rooms

  // scheduler state as the predictor sees it
  logic [NUM_W-1:0]  room_limit;
  logic [TIME_W-1:0] free_at [NROOMS];
  logic [CNT_W-1:0]  jobs_in_room [NROOMS];

  assignment_t due_assignments [$];
  assignment_t want;

  bit idle_en = 1'b1;  // random sender gaps and receiver stalls
  int mismatch_count = 0;
  int jobs_sent = 0;
  int results_checked = 0;
  int batches_closed = 0;
  int count_writes = 0;
  int cycle_count = 0;

  earliest_free_room_scheduler_top #(.ROOMS(NROOMS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_rooms();
    for (int i = 0; i < NROOMS; i++) begin
      free_at[i] = '0;
      jobs_in_room[i] = '0;
    end
  endtask

  // lowest free room at the start time, else the earliest to free up
  function automatic assignment_t assign_room(input logic [START_W-1:0] t_req,
                                              input logic [START_W-1:0] t_stop,
                                              input logic last_job);
    assignment_t r;
    logic [TIME_W-1:0] req48, dur, t0;
    int n, pick, early;
    bit found;
    n = int'(room_limit);
    if (n == 0) n = 1;        // zero rooms behaves as one
    if (n > NROOMS) n = NROOMS;
    req48 = TIME_W'(t_req);
    dur = (t_stop > t_req) ? TIME_W'(t_stop - t_req) : '0;  // negative length is zero
    pick = 0;
    early = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && free_at[i] <= req48) begin
        found = 1'b1;
        pick = i;
      end
      if (free_at[i] < free_at[early]) early = i;
    end
    if (!found) pick = early;
    t0 = (free_at[pick] > req48) ? free_at[pick] : req48;
    r.room = ROOM_W'(pick);
    r.t_start = t0;
    r.t_stop = (t0 > TIME_MAX - dur) ? TIME_MAX : t0 + dur;
    free_at[pick] = r.t_stop;
    if (jobs_in_room[pick] != COUNT_MAX) jobs_in_room[pick] = jobs_in_room[pick] + 1'b1;
    // most used room among the rooms in use, lowest index wins ties
    r.top_room = '0;
    r.top_count = jobs_in_room[0];
    for (int i = 1; i < n; i++) begin
      if (jobs_in_room[i] > r.top_count) begin
        r.top_count = jobs_in_room[i];
        r.top_room = ROOM_W'(i);
      end
    end
    r.last_flag = last_job;
    // end of batch wipes every room, the room count stays
    if (last_job) begin
      for (int i = 0; i < NROOMS; i++) begin
        free_at[i] = '0;
        jobs_in_room[i] = '0;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
               exp_val);
  endtask

  // every accepted result is held against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_assignments.size() == 0) begin
        log_mismatch("result with no request pending", 64'(out_tdata[3:0]), 64'd0);
      end else begin
        want = due_assignments.pop_front();
        results_checked++;
        if (out_tdata[3:0] !== want.room)
          log_mismatch("room_index", 64'(out_tdata[3:0]), 64'(want.room));
        if (out_tdata[51:4] !== want.t_start)
          log_mismatch("actual_start", 64'(out_tdata[51:4]), 64'(want.t_start));
        if (out_tdata[99:52] !== want.t_stop)
          log_mismatch("actual_end", 64'(out_tdata[99:52]), 64'(want.t_stop));
        if (out_tdata[103:100] !== want.top_room)
          log_mismatch("most_used_room", 64'(out_tdata[103:100]), 64'(want.top_room));
        if (out_tdata[135:104] !== want.top_count)
          log_mismatch("most_used_count", 64'(out_tdata[135:104]), 64'(want.top_count));
        if (out_tlast !== want.last_flag)
          log_mismatch("is_final", 64'(out_tlast), 64'(want.last_flag));
      end
    end
  end

  // receiver side: random stall bursts while idling is on, else always ready
  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one job request; valid stays high on return so the next job can follow
  task automatic send_job(input logic [START_W-1:0] t_req,
                          input logic [START_W-1:0] t_stop, input logic last_job);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tdata <= {t_stop, t_req};
    in_tlast <= last_job;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    due_assignments.push_back(assign_room(t_req, t_stop, last_job));
    jobs_sent++;
    if (last_job) batches_closed++;
  endtask

  // drop valid and let every pending result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_assignments.size() != 0) @(posedge clk);
  endtask

  // room count write, only once the block has gone quiet
  task automatic set_room_count(input logic [NUM_W-1:0] n);
    wait_for_results();
    @(negedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    room_limit = n;
    count_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset room count, all-zero and all-one fields, negative length
  task automatic test_defaults_and_extremes();
    send_job(32'd0, 32'd0, 1'b0);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_job(32'd5, 32'd3, 1'b0);
    send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // zero, one, largest and over-range room counts
  task automatic test_room_count_bounds();
    set_room_count(5'd0);   // acts as one room, jobs queue behind each other
    send_job(32'd10, 32'd20, 1'b0);
    send_job(32'd10, 32'd30, 1'b0);
    send_job(32'd15, 32'd16, 1'b1);
    set_room_count(5'd31);  // clipped to the built room count
    send_job(32'd0, 32'd100, 1'b0);
    send_job(32'd0, 32'd100, 1'b1);
    set_room_count(5'd17);
    send_job(32'd7, 32'd9, 1'b1);
    set_room_count(5'd1);
    send_job(32'd1, 32'd4, 1'b0);
    send_job(32'd2, 32'd3, 1'b1);
  endtask

  // rooms left out by a smaller count keep their state for later
  task automatic test_resize_mid_batch();
    set_room_count(5'd4);
    repeat (4) send_job(32'd0, 32'd1000, 1'b0);
    set_room_count(5'd2);
    send_job(32'd10, 32'd20, 1'b0);
    set_room_count(5'd4);
    send_job(32'd20, 32'd30, 1'b0);
    send_job(32'd25, 32'd2000, 1'b1);
  endtask

  // a start below an earlier one goes by the same rule
  task automatic test_start_order_broken();
    set_room_count(5'd3);
    send_job(32'd100, 32'd200, 1'b0);
    send_job(32'd50, 32'd60, 1'b0);
    send_job(32'd40, 32'd300, 1'b1);
  endtask

  // batches of jobs with mostly rising starts and crowded rooms,
  // with some noise: falling starts, negative lengths, unclosed batches
  task automatic test_random_batches();
    logic [NUM_W-1:0] sweep [10];
    logic [START_W-1:0] t_req, t_stop, step;
    logic [START_W:0] wide;
    int phase, done, batch_len, r;
    bit close;
    sweep = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31};
    phase = 0;
    done = 0;
    while (done < RANDOM_JOBS) begin
      set_room_count(phase < 10 ? sweep[phase] : NUM_W'($urandom_range(0, 31)));
      idle_en = (phase % 3) != 2;  // every third phase runs flat out
      repeat ($urandom_range(2, 5)) begin
        batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 20);
        close = $urandom_range(0, 9) != 0;
        case ($urandom_range(0, 3))
          0: t_req = $urandom;
          1: t_req = 32'hFFFF_FFFF - $urandom_range(0, 200);
          default: t_req = $urandom_range(0, 100);
        endcase
        for (int k = 0; k < batch_len; k++) begin
          if (k > 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
              step = $urandom_range(1, 50);
              t_req = (t_req >= step) ? t_req - step : '0;
            end else begin
              if (r < 4) step = '0;
              else if (r < 17) step = $urandom_range(0, 15);
              else step = $urandom_range(0, 1 << 20);
              wide = t_req + step;
              t_req = wide[START_W] ? '1 : wide[START_W-1:0];
            end
          end
          r = $urandom_range(0, 19);
          if (r < 11) step = $urandom_range(1, 60);
          else if (r < 13) step = '0;
          else step = $urandom;
          wide = t_req + step;
          t_stop = wide[START_W] ? '1 : wide[START_W-1:0];
          if (r == 13 || r == 14) begin
            step = $urandom_range(1, 1000);
            t_stop = (t_req >= step) ? t_req - step : '0;
          end else if (r >= 18) begin
            t_stop = $urandom;
          end
          send_job(t_req, t_stop, close && k == batch_len - 1);
          done++;
        end
      end
      phase++;
    end
  endtask

  // one room, maximal jobs back to back so the free time climbs past 32 bits
  task automatic test_long_jobs();
    idle_en = 1'b0;
    set_room_count(5'd1);
    repeat (LONG_JOBS) send_job(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_job(32'd0, 32'd5, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    room_limit = NUM_RESET;
    clear_rooms();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults_and_extremes();
    test_room_count_bounds();
    test_resize_mid_batch();
    test_start_order_broken();
    test_random_batches();
    test_long_jobs();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d jobs in %0d closed batches, %0d room count writes", jobs_sent,
             batches_closed, count_writes);
    $display("checked %0d assignments, %0d mismatches, %0d cycles", results_checked,
             mismatch_count, cycle_count);
    if (mismatch_count == 0 && due_assignments.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hung handshake guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at the cycle limit, %0d results still pending",
             due_assignments.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
